@@ rtl/core/rbd_pkg.sv @@
package rbd_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ       = 3'd4,
    CMD_INSERT     = 3'd5,
    CMD_ERASE      = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ERASE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     scan_load;
    logic     scan_shift;
  } cell_ctrl_t;

endpackage

@@ rtl/core/rbd_cell.sv @@
module rbd_cell import rbd_pkg::*; #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned XW         = 5
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [XW-1:0]         pos_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] scan_right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] scan_o
);

  localparam logic [XW-1:0] Idx = XW'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] scan_q, scan_d;

  // A cell at the insert point takes the new word, cells behind it take the
  // word of their front neighbor; on erase the cells from the gap backward
  // take the word of their back neighbor.
  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (Idx == pos_i) begin
          data_d = value_i;
        end else if (Idx > pos_i) begin
          data_d = left_i;
        end
      end
      OP_ERASE: begin
        if (Idx >= pos_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_comb begin
    scan_d = scan_q;
    if (ctrl_i.scan_load) begin
      scan_d = data_q;
    end else if (ctrl_i.scan_shift) begin
      scan_d = scan_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    scan_q <= scan_d;
  end

  assign data_o = data_q;
  assign scan_o = scan_q;

endmodule

@@ rtl/core/ring_buffer_deque_core.sv @@
// Double-ended queue of DEPTH words built as a row of cells, cell k holding
// the word at logical position k from the front.
// Requests arrive on the s_axis channel and each one gives exactly one
// result on the m_axis channel, in order.
// Push, pop front, insert and erase move the words of the cells at and behind
// the position at once in the cycle the request is accepted. Pushes, inserts,
// erases and rejected requests return their result in the cycle after acceptance.
// Reads and pops copy the row into a scan line that moves one cell toward
// the front per cycle until the addressed word (position 0 for pop front, the
// last position for pop back) reaches the front cell; the word is registered
// as the result once the output register is free, and the next request is
// accepted once that result is registered.
// The output register holds a result until it is taken. While it is full
// and the receiver stalls, no new request is accepted; a request is taken in
// the same cycle that the waiting result leaves.
// Reset empties the queue and clears the output register; the words held in
// the cells are not cleared and are only read after they were written.
module ring_buffer_deque_core import rbd_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // command [2:0], position [7:3], value [39:8]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // read_value [31:0], count [36:32], status [38:37], zero [39]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   rem_q;
  logic [CW-1:0]   pend_count_q;
  status_e         pend_status_q;
  logic            out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  cmd_e                  in_cmd;
  logic [POS_W-1:0]      in_pos;
  logic [DATA_WIDTH-1:0] in_value;
  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          full;
  logic          empty;

  cell_op_e      dec_op;
  logic [XW-1:0] dec_pos;
  status_e       dec_status;
  logic          dec_read;
  logic [CW-1:0] dec_idx;
  logic [CW-1:0] dec_count;

  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] data_w  [DEPTH];
  logic [DATA_WIDTH-1:0] left_w  [DEPTH];
  logic [DATA_WIDTH-1:0] right_w [DEPTH];
  logic [DATA_WIDTH-1:0] scan_w  [DEPTH];
  logic [DATA_WIDTH-1:0] scan_in_w [DEPTH];

  assign in_cmd   = cmd_e'(s_axis_tdata[CMD_W-1:0]);
  assign in_pos   = s_axis_tdata[CMD_W+POS_W-1:CMD_W];
  assign in_value = DATA_WIDTH'(s_axis_tdata[CMD_W+POS_W+VALUE_W-1:CMD_W+POS_W]);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign pos_x = XW'(in_pos);
  assign cnt_x = XW'(count_q);
  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    dec_op     = OP_HOLD;
    dec_pos    = pos_x;
    dec_status = ST_OK;
    dec_read   = 1'b0;
    dec_idx    = '0;
    dec_count  = count_q;
    unique case (in_cmd)
      CMD_PUSH_BACK: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = OP_INSERT;
          dec_pos   = cnt_x;
          dec_count = count_q + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = OP_INSERT;
          dec_pos   = '0;
          dec_count = count_q + 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          dec_status = ST_RANGE;
        end else begin
          dec_read  = 1'b1;
          dec_idx   = count_q - 1'b1;
          dec_count = count_q - 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          dec_status = ST_RANGE;
        end else begin
          dec_read  = 1'b1;
          dec_op    = OP_ERASE;
          dec_pos   = '0;
          dec_count = count_q - 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_x >= cnt_x) begin
          dec_status = ST_RANGE;
        end else begin
          dec_read = 1'b1;
          dec_idx  = CW'(pos_x);
        end
      end
      CMD_INSERT: begin
        if (pos_x > cnt_x) begin
          dec_status = ST_RANGE;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = OP_INSERT;
          dec_count = count_q + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (pos_x >= cnt_x) begin
          dec_status = ST_RANGE;
        end else begin
          dec_op    = OP_ERASE;
          dec_count = count_q - 1'b1;
        end
      end
      default: dec_status = ST_RANGE;
    endcase
  end

  assign ctrl.op         = in_fire ? dec_op : OP_HOLD;
  assign ctrl.scan_load  = in_fire && dec_read;
  assign ctrl.scan_shift = (state_q == S_SCAN) && (rem_q != '0);

  assign out_load = ((state_q == S_IDLE) && in_fire && !dec_read) ||
                    ((state_q == S_SCAN) && (rem_q == '0) && out_free);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = data_w[i];
    end else begin : g_mid_left
      assign left_w[i] = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w[i]   = data_w[i];
      assign scan_in_w[i] = scan_w[i];
    end else begin : g_mid_right
      assign right_w[i]   = data_w[i+1];
      assign scan_in_w[i] = scan_w[i+1];
    end

    rbd_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH),
      .XW         (XW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .pos_i        (dec_pos),
      .value_i      (in_value),
      .left_i       (left_w[i]),
      .right_i      (right_w[i]),
      .scan_right_i (scan_in_w[i]),
      .data_o       (data_w[i]),
      .scan_o       (scan_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      rem_q         <= '0;
      pend_count_q  <= '0;
      pend_status_q <= ST_OK;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            count_q <= dec_count;
            if (dec_read) begin
              state_q       <= S_SCAN;
              rem_q         <= dec_idx;
              pend_count_q  <= dec_count;
              pend_status_q <= dec_status;
            end else begin
              out_data_q <= {1'b0, dec_status, COUNT_W'(dec_count), VALUE_W'(0)};
            end
          end
        end
        S_SCAN: begin
          if (rem_q != '0) begin
            rem_q <= rem_q - 1'b1;
          end else if (out_free) begin
            state_q    <= S_IDLE;
            out_data_q <= {1'b0, pend_status_q, COUNT_W'(pend_count_q),
                           VALUE_W'(scan_w[0])};
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/core/rbd_checker.sv @@
module rbd_checker import rbd_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;
  logic [VALUE_W-1:0]  out_value;

  assign out_value  = m_axis_tdata[VALUE_W-1:0];
  assign out_count  = m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W];
  assign out_status = m_axis_tdata[VALUE_W+COUNT_W+STATUS_W-1:VALUE_W+COUNT_W];

  // A rejected or failed request never returns data.
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_status != ST_OK) |-> out_value == '0)
    else $error("failed request returned data");

  // A push or insert rejected as full reports a full queue.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_status == ST_FULL) |-> out_count == COUNT_W'(DEPTH))
    else $error("full status with a count below the depth");

  // A new request is never taken while a stalled result waits.
  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request accepted while the output stalls");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A waiting request stays on the bus unchanged until it is taken.
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("waiting request changed");

endmodule

bind ring_buffer_deque_core rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (.*);

@@ test/testbench.sv @@
module testbench;
  import rbd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH_DEF + 8;
  localparam int unsigned LONG_STALL_CYCLES = 80;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct {
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] count;
    status_e            status;
  } deque_result_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    int unsigned        reps;
    bit                 typed;
    deque_result_t      result;
  } deque_step_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [VALUE_W-1:0] deque_words[$];
  deque_result_t      pending_results[$];
  deque_step_t        directed_steps[$];
  int unsigned        error_count = 0;
  int unsigned        burst_left = 0;
  bit                 long_stall_req = 1'b0;

  ring_buffer_deque_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("[ring_buffer_deque_core] ERROR");
    $finish;
  end

  // Applies one request to the logical contents and returns its result.
  function automatic deque_result_t deque_next_result(logic [CMD_W-1:0] cmd,
                                                       logic [POS_W-1:0] pos,
                                                       logic [VALUE_W-1:0] value);
    deque_result_t res;
    int            held;
    int            idx;
    held = deque_words.size();
    idx = int'(pos);
    res.read_value = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (held >= DEPTH_DEF) res.status = ST_FULL;
        else deque_words.insert(held, value);
      end
      CMD_PUSH_FRONT: begin
        if (held >= DEPTH_DEF) res.status = ST_FULL;
        else deque_words.insert(0, value);
      end
      CMD_POP_BACK: begin
        if (held == 0) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = deque_words[held-1];
          deque_words.delete(held-1);
        end
      end
      CMD_POP_FRONT: begin
        if (held == 0) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = deque_words[0];
          deque_words.delete(0);
        end
      end
      CMD_READ: begin
        if (idx >= held) res.status = ST_RANGE;
        else res.read_value = deque_words[idx];
      end
      CMD_INSERT: begin
        if (idx > held) res.status = ST_RANGE;
        else if (held >= DEPTH_DEF) res.status = ST_FULL;
        else deque_words.insert(idx, value);
      end
      CMD_ERASE: begin
        if (idx >= held) res.status = ST_RANGE;
        else deque_words.delete(idx);
      end
      default: res.status = ST_RANGE;
    endcase
    res.count = COUNT_W'(deque_words.size());
    return res;
  endfunction

  task automatic add_step(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                          logic [VALUE_W-1:0] value, int unsigned reps, bit typed,
                          logic [VALUE_W-1:0] rd, logic [COUNT_W-1:0] cnt, status_e st);
    deque_step_t step;
    step.cmd = cmd;
    step.pos = pos;
    step.value = value;
    step.reps = reps;
    step.typed = typed;
    step.result.read_value = rd;
    step.result.count = cnt;
    step.result.status = st;
    directed_steps.insert(directed_steps.size(), step);
  endtask

  // Offers one request in bursts with random gaps and records its expected result.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] value, bit typed,
                              deque_result_t typed_result);
    deque_result_t predicted;
    int unsigned   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {value, pos, cmd};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    predicted = deque_next_result(cmd, pos, value);
    pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
  endtask

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    if (error_count < MAX_REPORTS)
      $display("mismatch in %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[VALUE_W-1:0], '0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_axis_tdata[31:0] !== want.read_value)
          report_mismatch("read_value", m_axis_tdata[31:0], want.read_value);
        if (m_axis_tdata[36:32] !== want.count)
          report_mismatch("count", VALUE_W'(m_axis_tdata[36:32]), VALUE_W'(want.count));
        if (m_axis_tdata[38:37] !== want.status)
          report_mismatch("status", VALUE_W'(m_axis_tdata[38:37]), VALUE_W'(want.status));
        if (m_axis_tdata[39] !== 1'b0)
          report_mismatch("padding", VALUE_W'(m_axis_tdata[39]), '0);
      end
    end
  end

  // The receiver cycles through several stall patterns and, when asked,
  // holds off for a long stretch so that the block backs up.
  initial begin
    int unsigned cycle_cnt;
    int unsigned stall_left;
    cycle_cnt = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left = LONG_STALL_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case ((cycle_cnt / 50) % 4)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= cycle_cnt[0];
        endcase
      end
    end
  end

  initial begin
    deque_step_t   step;
    deque_result_t no_result;
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   pos;
    int unsigned   roll;
    int unsigned   held;
    bit            grow;

    no_result = '{read_value: '0, count: '0, status: ST_OK};

    add_step(CMD_POP_BACK,   5'd0,  32'd0,          1, 1'b1, 32'd0, 5'd0,  ST_RANGE);
    add_step(CMD_POP_FRONT,  5'd0,  32'd0,          1, 1'b1, 32'd0, 5'd0,  ST_RANGE);
    add_step(CMD_READ,       5'd0,  32'd0,          1, 1'b1, 32'd0, 5'd0,  ST_RANGE);
    add_step(CMD_ERASE,      5'd0,  32'd0,          1, 1'b1, 32'd0, 5'd0,  ST_RANGE);
    add_step(CMD_INSERT,     5'd1,  32'h0000_1234,  1, 1'b1, 32'd0, 5'd0,  ST_RANGE);
    add_step(CMD_UNUSED,     5'd31, 32'hFFFF_FFFF,  1, 1'b1, 32'd0, 5'd0,  ST_RANGE);
    add_step(CMD_INSERT,     5'd0,  32'hFFFF_FFFF,  1, 1'b1, 32'd0, 5'd1,  ST_OK);
    add_step(CMD_PUSH_BACK,  5'd0,  32'd0,          1, 1'b1, 32'd0, 5'd2,  ST_OK);
    add_step(CMD_PUSH_FRONT, 5'd31, 32'hA5A5_A5A5,  1, 1'b1, 32'd0, 5'd3,  ST_OK);
    add_step(CMD_READ,       5'd31, 32'd0,          1, 1'b1, 32'd0, 5'd3,  ST_RANGE);
    add_step(CMD_READ,       5'd2,  32'd0,          1, 1'b0, 32'd0, 5'd0,  ST_OK);
    add_step(CMD_INSERT,     5'd3,  32'h5A5A_5A5A,  1, 1'b0, 32'd0, 5'd0,  ST_OK);
    add_step(CMD_INSERT,     5'd1,  32'h0F0F_F0F0,  1, 1'b0, 32'd0, 5'd0,  ST_OK);
    add_step(CMD_ERASE,      5'd0,  32'd0,          1, 1'b0, 32'd0, 5'd0,  ST_OK);
    add_step(CMD_ERASE,      5'd3,  32'd0,          1, 1'b0, 32'd0, 5'd0,  ST_OK);
    add_step(CMD_POP_BACK,   5'd0,  32'd0,          1, 1'b0, 32'd0, 5'd0,  ST_OK);
    add_step(CMD_POP_FRONT,  5'd0,  32'd0,          1, 1'b0, 32'd0, 5'd0,  ST_OK);
    add_step(CMD_PUSH_BACK,  5'd0,  32'd0,         15, 1'b0, 32'd0, 5'd0,  ST_OK);
    add_step(CMD_PUSH_BACK,  5'd0,  32'hFFFF_FFFF,  1, 1'b1, 32'd0, 5'd16, ST_FULL);
    add_step(CMD_PUSH_FRONT, 5'd0,  32'hFFFF_FFFF,  1, 1'b1, 32'd0, 5'd16, ST_FULL);
    add_step(CMD_INSERT,     5'd16, 32'hFFFF_FFFF,  1, 1'b1, 32'd0, 5'd16, ST_FULL);
    add_step(CMD_INSERT,     5'd17, 32'hFFFF_FFFF,  1, 1'b1, 32'd0, 5'd16, ST_RANGE);
    add_step(CMD_ERASE,      5'd16, 32'd0,          1, 1'b1, 32'd0, 5'd16, ST_RANGE);
    add_step(CMD_READ,       5'd15, 32'd0,          1, 1'b0, 32'd0, 5'd0,  ST_OK);
    add_step(CMD_ERASE,      5'd12, 32'd0,          1, 1'b0, 32'd0, 5'd0,  ST_OK);
    add_step(CMD_INSERT,     5'd2,  32'h8000_0001,  1, 1'b0, 32'd0, 5'd0,  ST_OK);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      step = directed_steps[i];
      for (int r = 0; r < step.reps; r++)
        send_request(step.cmd, step.pos, (step.reps > 1) ? $urandom : step.value,
                     step.typed, step.result);
    end

    for (int n = 0; n < 550; n++) begin
      if (n == 100 || n == 350)
        long_stall_req = 1'b1;
      grow = ((n / 60) % 2) == 0;
      held = deque_words.size();
      roll = $urandom_range(0, 99);
      if (roll < 3) cmd = CMD_UNUSED;
      else if (roll < (grow ? 20 : 10)) cmd = CMD_PUSH_BACK;
      else if (roll < (grow ? 35 : 18)) cmd = CMD_PUSH_FRONT;
      else if (roll < (grow ? 43 : 34)) cmd = CMD_POP_BACK;
      else if (roll < (grow ? 51 : 50)) cmd = CMD_POP_FRONT;
      else if (roll < 68) cmd = CMD_READ;
      else if (roll < 85) cmd = CMD_INSERT;
      else cmd = CMD_ERASE;
      if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, held));
      else pos = POS_W'($urandom_range(0, 31));
      send_request(cmd, pos, $urandom, 1'b0, no_result);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("[ring_buffer_deque_core] OK");
    else
      $display("[ring_buffer_deque_core] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rbd_pkg.sv
rtl/core/rbd_cell.sv
rtl/core/ring_buffer_deque_core.sv
rtl/core/rbd_checker.sv
test/testbench.sv
